@@ hw/rtl/pbs_pkg.sv @@
`default_nettype none

package pbs_pkg;

  // Default sizes of the tick counters and of the switch history.
  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int HISTORY_BITS_DEF  = 8;

  // The duty table has a fixed depth of sixteen entries.
  localparam int DUTY_TABLE_DEPTH = 16;
  localparam int DUTY_POS_W       = $clog2(DUTY_TABLE_DEPTH);
  localparam int DUTY_W           = 8;

  // The switch sample counter is eight bits wide.
  localparam int SAMPLE_W = 8;

  // The hold that clears the error state is this many times the off hold.
  localparam int ERROR_CLEAR_FACTOR = 3;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int OFF_HOLD_W  = 15;
  localparam int TIMEOUT_W   = 16;
  localparam int STEP_W      = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFF_HOLD_TICKS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_TIMEOUT   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LED_STEP_PERIOD = 2'd3;

  localparam logic [SAMPLE_W-1:0]   DEBOUNCE_PERIOD_RST = 8'd2;
  localparam logic [OFF_HOLD_W-1:0] OFF_HOLD_TICKS_RST  = 15'd1176;
  localparam logic [TIMEOUT_W-1:0]  ERROR_TIMEOUT_RST   = 16'd5880;
  localparam logic [STEP_W-1:0]     LED_STEP_PERIOD_RST = 16'd10;

  localparam int STATE_CODE_W = 3;

  // Breathing LED duty curve: a rise to full brightness and back down.
  function automatic logic [DUTY_W-1:0] duty_lookup(input logic [DUTY_POS_W-1:0] pos);
    logic [DUTY_W-1:0] duty;
    case (pos)
      4'd0:    duty = 8'd0;
      4'd1:    duty = 8'd2;
      4'd2:    duty = 8'd4;
      4'd3:    duty = 8'd16;
      4'd4:    duty = 8'd32;
      4'd5:    duty = 8'd64;
      4'd6:    duty = 8'd128;
      4'd7:    duty = 8'd255;
      4'd8:    duty = 8'd255;
      4'd9:    duty = 8'd128;
      4'd10:   duty = 8'd64;
      4'd11:   duty = 8'd32;
      4'd12:   duty = 8'd16;
      4'd13:   duty = 8'd4;
      4'd14:   duty = 8'd2;
      4'd15:   duty = 8'd0;
      default: duty = 8'd0;
    endcase
    return duty;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pbs_in_if.sv @@
`default_nettype none

interface pbs_in_if;
  logic valid;
  logic ready;
  logic switch_level;
  logic ack_level;

  modport source (output valid, output switch_level, output ack_level, input ready);
  modport sink (input valid, input switch_level, input ack_level, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pbs_out_if.sv @@
`default_nettype none

interface pbs_out_if;
  logic                                valid;
  logic                                ready;
  logic [pbs_pkg::STATE_CODE_W-1:0]    state_code;
  logic                                power_out;
  logic                                request_out;
  logic                                led_latch;
  logic                                pulse_enable;
  logic [pbs_pkg::DUTY_W-1:0]          led_duty;
  logic                                button_pressed;

  modport source (
    output valid, output state_code, output power_out, output request_out,
    output led_latch, output pulse_enable, output led_duty, output button_pressed,
    input ready
  );
  modport sink (
    input valid, input state_code, input power_out, input request_out,
    input led_latch, input pulse_enable, input led_duty, input button_pressed,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/power_button_sequencer.sv @@
// Push-button power sequencer, advanced by one timer tick per input transaction.
// Input channel in_ch: each transaction is one tick carrying the raw switch level
// (1 open, 0 closed) and the acknowledge level from the powered partner.
// Output channel out_ch: exactly one transaction per tick, giving the mode after
// the tick, the power, request and LED latch levels, the pulse enable, the
// breathing LED duty and the debounced pressed flag.
// Configuration: cfg_we writes cfg_data into the register chosen by cfg_index
// (0 debounce period, 1 off hold ticks, 2 error timeout, 3 LED step period).
// Write only while no tick is in flight.
// A tick is captured in an input register; when it moves on, the whole update
// (debounce, counters, mode, latches) is computed in one pass of short logic
// and lands in the output register. Throughput is one tick per cycle while the
// receiver keeps up; the only storage on the path is those two registers.
// When the receiver stalls, the output transaction holds and the input register
// still takes one more tick; after that in_ch.ready drops until out_ch drains.
// Synchronous reset (rst_n low) puts the sequencer in OFF with all latches low,
// the switch history all open, counters cleared and the registers at defaults.
`default_nettype none

module power_button_sequencer #(
  parameter int COUNTER_WIDTH = pbs_pkg::COUNTER_WIDTH_DEF,
  parameter int HISTORY_BITS  = pbs_pkg::HISTORY_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [pbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [pbs_pkg::CFG_DATA_W-1:0]   cfg_data,
  pbs_in_if.sink                                in_ch,
  pbs_out_if.source                             out_ch
);

  // Counters are compared against registers of up to 16 bits and against three
  // times the 15-bit off hold, so comparisons are done at this common width.
  localparam int WIDE_W = (COUNTER_WIDTH > pbs_pkg::OFF_HOLD_W + 2) ?
                          COUNTER_WIDTH : pbs_pkg::OFF_HOLD_W + 2;

  typedef enum logic [pbs_pkg::STATE_CODE_W-1:0] {
    MODE_OFF   = 3'd0,
    MODE_START = 3'd1,
    MODE_ON    = 3'd2,
    MODE_STOP  = 3'd3,
    MODE_ERROR = 3'd4
  } mode_t;

  // Configuration registers.
  logic [pbs_pkg::SAMPLE_W-1:0]   dbnc_period_r;
  logic [pbs_pkg::OFF_HOLD_W-1:0] off_hold_r;
  logic [pbs_pkg::TIMEOUT_W-1:0]  err_timeout_r;
  logic [pbs_pkg::STEP_W-1:0]     led_step_r;

  // Input register.
  logic in_v_r;
  logic in_sw_r;
  logic in_ack_r;

  // Sequencer state.
  mode_t                           mode_r, mode_nxt;
  logic [HISTORY_BITS-1:0]         hist_r, hist_nxt;
  logic                            pressed_r, pressed_nxt;
  logic [pbs_pkg::SAMPLE_W-1:0]    sample_cnt_r, sample_cnt_nxt;
  logic [COUNTER_WIDTH-1:0]        hold_cnt_r, hold_cnt_nxt;
  logic [COUNTER_WIDTH-1:0]        wait_cnt_r, wait_cnt_nxt;
  logic [COUNTER_WIDTH-1:0]        flash_cnt_r, flash_cnt_nxt;
  logic [pbs_pkg::DUTY_POS_W-1:0]  pos_r, pos_nxt;
  logic [pbs_pkg::DUTY_W-1:0]      duty_r, duty_nxt;
  logic                            power_r, power_nxt;
  logic                            request_r, request_nxt;
  logic                            led_r, led_nxt;
  logic                            pulse_r, pulse_nxt;

  // Output register.
  logic                             out_v_r;
  logic [pbs_pkg::STATE_CODE_W-1:0] out_state_r;
  logic                             out_power_r;
  logic                             out_request_r;
  logic                             out_led_r;
  logic                             out_pulse_r;
  logic [pbs_pkg::DUTY_W-1:0]       out_duty_r;
  logic                             out_pressed_r;

  logic advance;
  logic sample_hit;
  logic [COUNTER_WIDTH-1:0] hold_track;
  logic [COUNTER_WIDTH-1:0] flash_step;
  logic [WIDE_W-1:0] clear_hold;
  logic wait_expired;
  logic flash_due;

  // The tick in the input register moves on when the output register is free
  // or is being emptied in this cycle.
  assign advance      = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || advance;

  always_comb begin
    mode_nxt       = mode_r;
    hold_cnt_nxt   = hold_cnt_r;
    wait_cnt_nxt   = wait_cnt_r;
    flash_cnt_nxt  = flash_cnt_r;
    pos_nxt        = pos_r;
    duty_nxt       = duty_r;
    power_nxt      = power_r;
    request_nxt    = request_r;
    led_nxt        = led_r;
    pulse_nxt      = pulse_r;

    // Switch debounce: shift in a sample each time the counter exceeds the period.
    sample_hit = sample_cnt_r > dbnc_period_r;
    hist_nxt   = sample_hit ? {hist_r[HISTORY_BITS-2:0], in_sw_r} : hist_r;
    pressed_nxt = pressed_r;
    if (sample_hit) begin
      if (hist_nxt == '0) begin
        pressed_nxt = 1'b1;
      end else if (hist_nxt == '1) begin
        pressed_nxt = 1'b0;
      end
    end
    sample_cnt_nxt = sample_hit ? '0 : sample_cnt_r + 1'b1;

    // Counters advance according to the mode held before the tick.
    hold_track = pressed_nxt ? hold_cnt_r + 1'b1 : '0;
    flash_step = (WIDE_W'(flash_cnt_r) > WIDE_W'(led_step_r)) ? '0 : flash_cnt_r + 1'b1;

    case (mode_r)
      MODE_OFF: begin
        hold_cnt_nxt = '0;
      end
      MODE_START: begin
        wait_cnt_nxt  = wait_cnt_r + 1'b1;
        flash_cnt_nxt = flash_step;
      end
      MODE_ON: begin
        wait_cnt_nxt = '0;
        hold_cnt_nxt = hold_track;
      end
      MODE_STOP: begin
        wait_cnt_nxt  = wait_cnt_r + 1'b1;
        flash_cnt_nxt = flash_step;
        hold_cnt_nxt  = '0;
      end
      MODE_ERROR: begin
        wait_cnt_nxt = '0;
        hold_cnt_nxt = hold_track;
      end
      default: begin
      end
    endcase

    // Mode update; a handshake timeout overrides the acknowledge.
    wait_expired = WIDE_W'(wait_cnt_nxt) > WIDE_W'(err_timeout_r);
    clear_hold   = (WIDE_W'(off_hold_r) << 1) + WIDE_W'(off_hold_r);

    case (mode_r)
      MODE_OFF: begin
        if (pressed_nxt) begin
          mode_nxt = MODE_START;
        end
      end
      MODE_START: begin
        if (wait_expired) begin
          mode_nxt = MODE_ERROR;
        end else if (in_ack_r) begin
          mode_nxt = MODE_ON;
        end
      end
      MODE_ON: begin
        if (WIDE_W'(hold_cnt_nxt) > WIDE_W'(off_hold_r)) begin
          mode_nxt = MODE_STOP;
        end
      end
      MODE_STOP: begin
        if (wait_expired) begin
          mode_nxt = MODE_ERROR;
        end else if (!in_ack_r) begin
          mode_nxt = MODE_OFF;
        end
      end
      MODE_ERROR: begin
        if (WIDE_W'(hold_cnt_nxt) > clear_hold) begin
          mode_nxt = MODE_OFF;
        end
      end
      default: begin
      end
    endcase

    // Output latches follow the new mode; the duty steps while breathing.
    flash_due = WIDE_W'(flash_cnt_nxt) > WIDE_W'(led_step_r);

    case (mode_nxt)
      MODE_OFF: begin
        power_nxt   = 1'b0;
        request_nxt = 1'b0;
        led_nxt     = 1'b0;
        pulse_nxt   = 1'b0;
      end
      MODE_START: begin
        power_nxt   = 1'b1;
        request_nxt = 1'b1;
        pulse_nxt   = 1'b1;
        if (flash_due) begin
          duty_nxt = pbs_pkg::duty_lookup(pos_r);
          pos_nxt  = pos_r + 1'b1;
        end
      end
      MODE_ON: begin
        pulse_nxt = 1'b0;
        led_nxt   = 1'b1;
      end
      MODE_STOP: begin
        request_nxt = 1'b0;
        pulse_nxt   = 1'b1;
        if (flash_due) begin
          duty_nxt = pbs_pkg::duty_lookup(pos_r);
          pos_nxt  = pos_r + 1'b1;
        end
      end
      MODE_ERROR: begin
        pulse_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbnc_period_r <= pbs_pkg::DEBOUNCE_PERIOD_RST;
      off_hold_r    <= pbs_pkg::OFF_HOLD_TICKS_RST;
      err_timeout_r <= pbs_pkg::ERROR_TIMEOUT_RST;
      led_step_r    <= pbs_pkg::LED_STEP_PERIOD_RST;
      in_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      mode_r        <= MODE_OFF;
      hist_r        <= '1;
      pressed_r     <= 1'b0;
      sample_cnt_r  <= '0;
      hold_cnt_r    <= '0;
      wait_cnt_r    <= '0;
      flash_cnt_r   <= '0;
      pos_r         <= '0;
      duty_r        <= '0;
      power_r       <= 1'b0;
      request_r     <= 1'b0;
      led_r         <= 1'b0;
      pulse_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pbs_pkg::CFG_DEBOUNCE_PERIOD: dbnc_period_r <= cfg_data[pbs_pkg::SAMPLE_W-1:0];
          pbs_pkg::CFG_OFF_HOLD_TICKS:  off_hold_r    <= cfg_data[pbs_pkg::OFF_HOLD_W-1:0];
          pbs_pkg::CFG_ERROR_TIMEOUT:   err_timeout_r <= cfg_data[pbs_pkg::TIMEOUT_W-1:0];
          pbs_pkg::CFG_LED_STEP_PERIOD: led_step_r    <= cfg_data[pbs_pkg::STEP_W-1:0];
          default: begin
          end
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        in_v_r   <= 1'b1;
        in_sw_r  <= in_ch.switch_level;
        in_ack_r <= in_ch.ack_level;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end

      if (advance) begin
        mode_r        <= mode_nxt;
        hist_r        <= hist_nxt;
        pressed_r     <= pressed_nxt;
        sample_cnt_r  <= sample_cnt_nxt;
        hold_cnt_r    <= hold_cnt_nxt;
        wait_cnt_r    <= wait_cnt_nxt;
        flash_cnt_r   <= flash_cnt_nxt;
        pos_r         <= pos_nxt;
        duty_r        <= duty_nxt;
        power_r       <= power_nxt;
        request_r     <= request_nxt;
        led_r         <= led_nxt;
        pulse_r       <= pulse_nxt;
        out_v_r       <= 1'b1;
        out_state_r   <= mode_nxt;
        out_power_r   <= power_nxt;
        out_request_r <= request_nxt;
        out_led_r     <= led_nxt;
        out_pulse_r   <= pulse_nxt;
        out_duty_r    <= duty_nxt;
        out_pressed_r <= pressed_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.state_code     = out_state_r;
  assign out_ch.power_out      = out_power_r;
  assign out_ch.request_out    = out_request_r;
  assign out_ch.led_latch      = out_led_r;
  assign out_ch.pulse_enable   = out_pulse_r;
  assign out_ch.led_duty       = out_duty_r;
  assign out_ch.button_pressed = out_pressed_r;

`ifndef SYNTH
  // A tick that leaves the input register always produces an output transaction.
  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("advanced tick did not reach the output register");

  // In OFF every latch is low and the LED does not breathe.
  a_off_all_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_state_r == MODE_OFF) |->
      (!out_power_r && !out_request_r && !out_led_r && !out_pulse_r))
    else $error("latch left high in OFF");

  // STOP is only reached from ON, so power stays up while request is dropped.
  a_stop_latches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_state_r == MODE_STOP) |-> (out_power_r && !out_request_r))
    else $error("wrong latch levels in STOP");
`endif

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the push-button power sequencer. Every tick that the
// block accepts is also run through a model of the sequencer kept in this file,
// and the status it predicts is queued. A separate process takes the block's
// status transactions and compares them, field by field, with the oldest entry
// in that queue.
module testbench;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 6;
  localparam int IDLE_MAX       = 18;
  localparam int SETTLE_CYCLES  = 6;
  localparam int STALL_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int EXTREME_TICKS  = 100;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_TICKS    = 130;

  // Breathing curve, one duty value per table position.
  localparam logic [pbs_pkg::DUTY_TABLE_DEPTH-1:0][pbs_pkg::DUTY_W-1:0] BREATH_CURVE = {
    8'd0, 8'd2, 8'd4, 8'd16, 8'd32, 8'd64, 8'd128, 8'd255,
    8'd255, 8'd128, 8'd64, 8'd32, 8'd16, 8'd4, 8'd2, 8'd0
  };

  // Sequencer modes, in the order of their state codes.
  typedef enum logic [pbs_pkg::STATE_CODE_W-1:0] {
    MODE_OFF, MODE_START, MODE_ON, MODE_STOP, MODE_ERROR
  } seq_mode_t;

  // One status transaction as it appears on the result channel.
  typedef struct packed {
    logic [pbs_pkg::STATE_CODE_W-1:0] state_code;
    logic                             power_out;
    logic                             request_out;
    logic                             led_latch;
    logic                             pulse_enable;
    logic [pbs_pkg::DUTY_W-1:0]       led_duty;
    logic                             button_pressed;
  } status_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [pbs_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [pbs_pkg::CFG_DATA_W-1:0]  cfg_data;

  pbs_in_if  in_ch ();
  pbs_out_if out_ch ();

  power_button_sequencer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shared control between the stimulus and the status receiver. When idle_on
  // is low neither side inserts gaps. A nonzero stall_cycles asks the receiver
  // to hold ready low for that many cycles, once.
  bit      idle_on;
  int      stall_cycles = 0;
  int      mismatch_count = 0;
  int      status_index = 0;
  int      quiet_cycles = 0;
  status_t expected_status[$];

  // Register copies, masked to their widths the same way the block masks them.
  logic [pbs_pkg::SAMPLE_W-1:0]   cfg_debounce;
  logic [pbs_pkg::OFF_HOLD_W-1:0] cfg_off_hold;
  logic [pbs_pkg::TIMEOUT_W-1:0]  cfg_timeout;
  logic [pbs_pkg::STEP_W-1:0]     cfg_step;

  // Sequencer state as predicted from the accepted ticks.
  seq_mode_t                             seq_mode;
  logic [pbs_pkg::HISTORY_BITS_DEF-1:0]  switch_hist;
  logic                                  pressed;
  logic [pbs_pkg::SAMPLE_W-1:0]          sample_cnt;
  logic [pbs_pkg::COUNTER_WIDTH_DEF-1:0] hold_cnt;
  logic [pbs_pkg::COUNTER_WIDTH_DEF-1:0] wait_cnt;
  logic [pbs_pkg::COUNTER_WIDTH_DEF-1:0] flash_cnt;
  logic [pbs_pkg::DUTY_POS_W-1:0]        breath_pos;
  logic [pbs_pkg::DUTY_W-1:0]            duty;
  logic                                  lat_power;
  logic                                  lat_request;
  logic                                  lat_led;
  logic                                  pulse_on;

  // Advances the sequencer by one tick and queues the status it must report.
  // The order matters: the switch is sampled first, then the counters move in
  // the mode held before the tick, then the mode changes, and the latches
  // follow the new mode.
  task automatic advance_sequencer(input logic sw, input logic ack);
    logic    sample_now;
    status_t outcome;
    sample_now = sample_cnt > cfg_debounce;
    if (sample_now) begin
      switch_hist = {switch_hist[pbs_pkg::HISTORY_BITS_DEF-2:0], sw};
      // Eight closed samples in a row make a press, eight open ones a release;
      // anything in between leaves the flag alone.
      if (switch_hist == '0) pressed = 1'b1;
      else if (switch_hist == '1) pressed = 1'b0;
    end
    sample_cnt = sample_now ? '0 : sample_cnt + 1'b1;

    case (seq_mode)
      MODE_OFF: hold_cnt = '0;
      MODE_ON, MODE_ERROR: begin
        wait_cnt = '0;
        hold_cnt = pressed ? hold_cnt + 1'b1 : '0;
      end
      MODE_START, MODE_STOP: begin
        wait_cnt  = wait_cnt + 1'b1;
        flash_cnt = (flash_cnt > cfg_step) ? '0 : flash_cnt + 1'b1;
        if (seq_mode == MODE_STOP) hold_cnt = '0;
      end
      default: ;
    endcase

    // In START and STOP the timeout wins over the acknowledge.
    case (seq_mode)
      MODE_OFF: if (pressed) seq_mode = MODE_START;
      MODE_START: begin
        if (ack) seq_mode = MODE_ON;
        if (wait_cnt > cfg_timeout) seq_mode = MODE_ERROR;
      end
      MODE_ON: if (hold_cnt > cfg_off_hold) seq_mode = MODE_STOP;
      MODE_STOP: begin
        if (!ack) seq_mode = MODE_OFF;
        if (wait_cnt > cfg_timeout) seq_mode = MODE_ERROR;
      end
      MODE_ERROR: begin
        // The clearing hold is compared at full precision, so a long off hold
        // can put it beyond the reach of the counter.
        if (int'(hold_cnt) > pbs_pkg::ERROR_CLEAR_FACTOR * int'(cfg_off_hold))
          seq_mode = MODE_OFF;
      end
      default: ;
    endcase

    case (seq_mode)
      MODE_OFF: begin
        lat_power   = 1'b0;
        lat_request = 1'b0;
        lat_led     = 1'b0;
        pulse_on    = 1'b0;
      end
      MODE_START, MODE_STOP: begin
        if (seq_mode == MODE_START) begin
          lat_power   = 1'b1;
          lat_request = 1'b1;
        end else begin
          lat_request = 1'b0;
        end
        pulse_on = 1'b1;
        if (flash_cnt > cfg_step) begin
          duty       = BREATH_CURVE[breath_pos];
          breath_pos = breath_pos + 1'b1;
        end
      end
      MODE_ON: begin
        pulse_on = 1'b0;
        lat_led  = 1'b1;
      end
      MODE_ERROR: pulse_on = 1'b0;
      default: ;
    endcase

    outcome.state_code     = seq_mode;
    outcome.power_out      = lat_power;
    outcome.request_out    = lat_request;
    outcome.led_latch      = lat_led;
    outcome.pulse_enable   = pulse_on;
    outcome.led_duty       = duty;
    outcome.button_pressed = pressed;
    expected_status.push_back(outcome);
  endtask

  task automatic report_mismatch(input string field, input int seen, input int want);
    $display("[%0t] status %0d: %s is %0d, expected %0d", $time, status_index, field,
             seen, want);
    mismatch_count++;
  endtask

  // Offers one tick and waits until the block takes it. Valid stays high from
  // one tick to the next unless a gap is drawn.
  task automatic send_tick(input logic sw, input logic ack);
    int gap;
    gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.switch_level <= sw;
    in_ch.ack_level    <= ack;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    advance_sequencer(sw, ack);
  endtask

  task automatic send_run(input logic sw, input logic ack, input int count);
    repeat (count) send_tick(sw, ack);
  endtask

  // Holds both levels until the predicted mode reaches the goal, or gives up
  // after cap ticks.
  task automatic hold_levels_until(input logic sw, input logic ack, input seq_mode_t goal,
                                   input int cap);
    int n;
    n = 0;
    while (seq_mode != goal && n < cap) begin
      send_tick(sw, ack);
      n++;
    end
  endtask

  // Stops offering ticks and waits until every status has come back. Each
  // tick gives exactly one status, so an empty queue means the block is idle;
  // a settling pause follows as a margin.
  task automatic wait_until_idle();
    in_ch.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers back to back, only while the block is idle.
  task automatic apply_settings(input logic [pbs_pkg::CFG_DATA_W-1:0] deb,
                                input logic [pbs_pkg::CFG_DATA_W-1:0] off_hold,
                                input logic [pbs_pkg::CFG_DATA_W-1:0] timeout,
                                input logic [pbs_pkg::CFG_DATA_W-1:0] step);
    wait_until_idle();
    cfg_we    <= 1'b1;
    cfg_index <= pbs_pkg::CFG_DEBOUNCE_PERIOD;
    cfg_data  <= deb;
    @(posedge clk);
    cfg_index <= pbs_pkg::CFG_OFF_HOLD_TICKS;
    cfg_data  <= off_hold;
    @(posedge clk);
    cfg_index <= pbs_pkg::CFG_ERROR_TIMEOUT;
    cfg_data  <= timeout;
    @(posedge clk);
    cfg_index <= pbs_pkg::CFG_LED_STEP_PERIOD;
    cfg_data  <= step;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_debounce = deb[pbs_pkg::SAMPLE_W-1:0];
    cfg_off_hold = off_hold[pbs_pkg::OFF_HOLD_W-1:0];
    cfg_timeout  = timeout[pbs_pkg::TIMEOUT_W-1:0];
    cfg_step     = step[pbs_pkg::STEP_W-1:0];
    @(posedge clk);
  endtask

  // With the reset settings and the switch open the block must sit in OFF,
  // whatever the acknowledge does.
  task automatic test_reset_defaults();
    send_run(1'b1, 1'b0, 4);
    send_run(1'b1, 1'b1, 3);
    send_run(1'b1, 1'b0, 2);
  endtask

  // A complete power cycle: press, acknowledge, long hold to power down, then
  // release and drop the acknowledge.
  task automatic test_power_cycle();
    apply_settings(16'd0, 16'd3, 16'd40, 16'd1);
    hold_levels_until(1'b0, 1'b0, MODE_START, 30);
    send_run(1'b0, 1'b0, 4);
    hold_levels_until(1'b0, 1'b1, MODE_ON, 10);
    hold_levels_until(1'b0, 1'b1, MODE_STOP, 20);
    send_run(1'b1, 1'b1, 2);
    hold_levels_until(1'b1, 1'b0, MODE_OFF, 10);
  endtask

  // Both handshakes running out: no acknowledge in START, and an acknowledge
  // that never falls in STOP. Each error is cleared by a triple-length hold.
  task automatic test_handshake_timeouts();
    apply_settings(16'd0, 16'd2, 16'd5, 16'd0);
    hold_levels_until(1'b0, 1'b0, MODE_START, 30);
    hold_levels_until(1'b0, 1'b0, MODE_ERROR, 20);
    hold_levels_until(1'b0, 1'b0, MODE_OFF, 20);
    hold_levels_until(1'b0, 1'b1, MODE_ON, 10);
    hold_levels_until(1'b0, 1'b1, MODE_STOP, 10);
    hold_levels_until(1'b0, 1'b1, MODE_ERROR, 20);
    send_run(1'b1, 1'b1, 4);
    hold_levels_until(1'b0, 1'b0, MODE_OFF, 30);
    send_run(1'b1, 1'b0, 20);
  endtask

  // The debouncer: a clean press, a bouncing switch that must not change the
  // flag, a release, and the longest period, which never takes a sample.
  task automatic test_debounce_filter();
    apply_settings(16'd1, 16'd4, 16'd60, 16'd2);
    send_run(1'b0, 1'b1, 28);
    for (int k = 0; k < 20; k++) send_tick(k[0], 1'b1);
    send_run(1'b1, 1'b0, 30);
    apply_settings(16'hFFFF, 16'd4, 16'd60, 16'd2);
    send_run(1'b0, 1'b0, 12);
  endtask

  // Runs without gaps at the extreme register values. Zero debounce, off hold
  // and timeout drive the block straight into ERROR and out again; then START
  // is held with a timeout and a step period that cannot be exceeded, and ERROR
  // is held with an off hold whose triple lies beyond the counter range.
  task automatic test_extreme_settings();
    idle_on = 1'b0;
    apply_settings(16'd0, 16'd0, 16'd0, 16'hFFFF);
    hold_levels_until(1'b0, 1'b0, MODE_ERROR, 200);
    hold_levels_until(1'b0, 1'b0, MODE_OFF, 10);
    apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    hold_levels_until(1'b0, 1'b0, MODE_START, 10);
    send_run(1'b0, 1'b0, EXTREME_TICKS);
    apply_settings(16'd0, 16'hFFFF, 16'd3, 16'hFFFF);
    hold_levels_until(1'b0, 1'b0, MODE_ERROR, 10);
    send_run(1'b0, 1'b0, EXTREME_TICKS);
    apply_settings(16'd0, 16'd0, 16'd3, 16'hFFFF);
    hold_levels_until(1'b0, 1'b0, MODE_OFF, 10);
    idle_on = 1'b1;
  endtask

  // The receiver stops for a long stretch while ticks keep coming, so the
  // block must fill up and drop its ready.
  task automatic test_backpressure();
    idle_on      = 1'b0;
    stall_cycles = STALL_CYCLES;
    for (int k = 0; k < 40; k++)
      send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    idle_on = 1'b1;
  endtask

  // Random sessions. Each phase picks settings (the lowest and highest values
  // first), then plays runs of switch levels of random length. Most runs have
  // a partner that answers the request line, which walks the block through its
  // whole handshake; the rest hold the acknowledge at random so that timeouts
  // happen. A tick now and then has a flipped switch level as noise.
  task automatic test_random_sessions();
    logic [pbs_pkg::CFG_DATA_W-1:0] deb;
    logic [pbs_pkg::CFG_DATA_W-1:0] off_hold;
    logic [pbs_pkg::CFG_DATA_W-1:0] timeout;
    logic [pbs_pkg::CFG_DATA_W-1:0] step;
    logic                           sw;
    logic                           ack_hold;
    bit                             partner;
    int                             run;
    int                             total;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          deb = '0; off_hold = '0; timeout = '0; step = '0;
        end
        1: begin
          deb = 16'd0; off_hold = 16'hFFFF; timeout = 16'hFFFF; step = 16'hFFFF;
        end
        2: begin
          deb = 16'd254; off_hold = 16'd6; timeout = 16'd400; step = 16'd3;
        end
        default: begin
          // Bits above the debounce and off hold widths are filled at random; the
          // block must ignore them.
          deb      = {8'($urandom), 8'($urandom_range(0, 3))};
          off_hold = {1'($urandom), 15'($urandom_range(0, 12))};
          timeout  = 16'($urandom_range(0, 50));
          step     = 16'($urandom_range(0, 4));
        end
      endcase
      apply_settings(deb, off_hold, timeout, step);
      idle_on  = (phase == 0) || ($urandom_range(0, 3) != 0);
      sw       = 1'b1;
      ack_hold = 1'b0;
      total    = 0;
      while (total < PHASE_TICKS) begin
        run      = $urandom_range(1, 60);
        partner  = $urandom_range(0, 3) != 0;
        ack_hold = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) < 7) sw = ~sw;
        for (int k = 0; k < run && total < PHASE_TICKS; k++) begin
          send_tick(($urandom_range(0, 29) == 0) ? ~sw : sw,
                    partner ? lat_request : ack_hold);
          total++;
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // Status receiver: draws a gap before each transaction, honors a requested
  // stall, and checks every accepted status against the oldest prediction.
  initial begin : status_receiver
    status_t seen;
    status_t want;
    int      gap;
    int      pause;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_cycles > 0) begin
        pause        = stall_cycles;
        stall_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      seen.state_code     = out_ch.state_code;
      seen.power_out      = out_ch.power_out;
      seen.request_out    = out_ch.request_out;
      seen.led_latch      = out_ch.led_latch;
      seen.pulse_enable   = out_ch.pulse_enable;
      seen.led_duty       = out_ch.led_duty;
      seen.button_pressed = out_ch.button_pressed;
      if (expected_status.size() == 0) begin
        report_mismatch("status with no tick behind it, state_code",
                        int'(seen.state_code), 0);
      end else begin
        want = expected_status.pop_front();
        if (seen.state_code !== want.state_code)
          report_mismatch("state_code", int'(seen.state_code), int'(want.state_code));
        if (seen.power_out !== want.power_out)
          report_mismatch("power_out", int'(seen.power_out), int'(want.power_out));
        if (seen.request_out !== want.request_out)
          report_mismatch("request_out", int'(seen.request_out), int'(want.request_out));
        if (seen.led_latch !== want.led_latch)
          report_mismatch("led_latch", int'(seen.led_latch), int'(want.led_latch));
        if (seen.pulse_enable !== want.pulse_enable)
          report_mismatch("pulse_enable", int'(seen.pulse_enable),
                          int'(want.pulse_enable));
        if (seen.led_duty !== want.led_duty)
          report_mismatch("led_duty", int'(seen.led_duty), int'(want.led_duty));
        if (seen.button_pressed !== want.button_pressed)
          report_mismatch("button_pressed", int'(seen.button_pressed),
                          int'(want.button_pressed));
      end
      status_index++;
    end
  end

  // Watchdog: the run is hung if no transaction moves on either channel for
  // far longer than the longest stall, gap or settling pause.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= pbs_pkg::CFG_DEBOUNCE_PERIOD;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.switch_level <= 1'b1;
    in_ch.ack_level    <= 1'b0;
    idle_on            = 1'b1;

    // The model starts where reset leaves the block: OFF, switch open, all
    // counters and latches clear, registers at their defaults.
    cfg_debounce = pbs_pkg::DEBOUNCE_PERIOD_RST;
    cfg_off_hold = pbs_pkg::OFF_HOLD_TICKS_RST;
    cfg_timeout  = pbs_pkg::ERROR_TIMEOUT_RST;
    cfg_step     = pbs_pkg::LED_STEP_PERIOD_RST;
    seq_mode     = MODE_OFF;
    switch_hist  = '1;
    pressed      = 1'b0;
    sample_cnt   = '0;
    hold_cnt     = '0;
    wait_cnt     = '0;
    flash_cnt    = '0;
    breath_pos   = '0;
    duty         = '0;
    lat_power    = 1'b0;
    lat_request  = 1'b0;
    lat_led      = 1'b0;
    pulse_on     = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_power_cycle();
    test_handshake_timeouts();
    test_debounce_filter();
    test_extreme_settings();
    test_backpressure();
    test_random_sessions();

    // Every tick has been taken; wait for the last status and let the
    // pipeline settle before the verdict.
    wait_until_idle();
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pbs_pkg.sv
hw/rtl/pbs_in_if.sv
hw/rtl/pbs_out_if.sv
hw/rtl/power_button_sequencer.sv
tb/sv/testbench.sv
